FILE: sv/cluster_bitmap_allocator_macros.svh
// Assertion macros shared by the cluster bitmap allocator RTL.
`ifndef CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH
`define CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CBA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cluster_bitmap_allocator: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CBA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cluster_bitmap_allocator: next-cycle check failed");

`endif

FILE: sv/cba_pkg.sv
// Shared types, sizes and codes of the cluster bitmap allocator.
`timescale 1ns / 1ps

package cba_pkg;

    // Size of the used map, in clusters.
    localparam int MAX_CLUSTERS = 1024;

    // Fixed widths of the interface fields.
    localparam int COUNT_W     = 11;
    localparam int IDX_FIELD_W = 10;

    // Map organization: one memory word holds WORD_W marks.
    localparam int WORD_W    = (MAX_CLUSTERS < 64) ? MAX_CLUSTERS : 64;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = MAX_CLUSTERS / WORD_W;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_CLUSTERS + 1);
    localparam int CMP_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

    typedef logic [WORD_W-1:0]      word_t;
    typedef logic [BIT_W-1:0]       bitpos_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [CMP_W-1:0]       cmp_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [IDX_FIELD_W-1:0] idx_field_t;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_MARK  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Request from the controller to the map memory.
    typedef struct packed {
        logic  rd_en;
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } mem_req_t;

endpackage

FILE: sv/cba_mark_ram.sv
// Used-mark memory: registered synchronous read, per-word valid bits for reset.
`timescale 1ns / 1ps

module cba_mark_ram
    import cba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output word_t    rd_data
);

    word_t                mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    word_t                rd_data_reg;

    // A word that was never written since reset reads as all free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/cba_free_find.sv
// Lowest free mark within one map word, limited to clusters below the active count.
`timescale 1ns / 1ps

module cba_free_find
    import cba_pkg::*;
(
    input  word_t   word,
    input  cnt_t    base,
    input  cnt_t    active,
    output logic    found,
    output bitpos_t pos
);

    cnt_t  rem;
    word_t avail;

    always_comb
    begin
        rem = (active > base) ? (active - base) : '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            avail[b] = !word[b] && (cnt_t'(b) < rem);
        end
    end

    always_comb
    begin
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pos = bitpos_t'(b);
            end
        end
    end

    assign found = |avail;

endmodule

FILE: sv/cluster_bitmap_allocator.sv
// Top level of the cluster bitmap allocator: request control, result register, config.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  s_*       in         tuser = kind, tdata = cluster_index
//  m_*       out        tuser = status, tdata = result_index, is_free
//  cfg_*     in         cfg_data = active cluster total
//
//  Allocate reads k map words (1 to 16 at 1024 clusters): one word of 64
//  marks is read from the map memory per cycle and searched for its
//  lowest free mark.
//  Free, mark-used and query go through read, modify/write and result;
//  an out-of-range index goes straight to the result and leaves the map alone.
//  Reset clears the map at once through per-word valid bits; no sweep.
//  A new request is taken while the previous result still waits on m_*;
//  the block stalls only when a second result is ready before that one leaves.
//

`include "cluster_bitmap_allocator_macros.svh"

module cluster_bitmap_allocator
    import cba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] cluster_index, [15:10] zero
    input  logic [1:0]  s_tuser,    // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [9:0] result_index, [10] is_free, [15:11] zero
    output logic [1:0]  m_tuser,    // [1:0] status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data    // [10:0] active cluster total
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RESP
    } state_t;

    state_t     state_reg,      state_next;
    kind_t      kind_reg,       kind_next;
    idx_field_t idx_reg,        idx_next;
    addr_t      word_addr_reg,  word_addr_next;
    bitpos_t    bit_reg,        bit_next;
    status_t    res_status_reg, res_status_next;
    idx_field_t res_index_reg,  res_index_next;
    logic       res_free_reg,   res_free_next;
    logic       m_valid_reg,    m_valid_next;
    status_t    m_status_reg,   m_status_next;
    idx_field_t m_index_reg,    m_index_next;
    logic       m_free_reg,     m_free_next;
    count_t     count_reg;

    mem_req_t   mem_req;
    word_t      rd_word;
    cnt_t       active;
    cnt_t       base;
    cnt_t       req_full;
    logic       hit;
    bitpos_t    hit_pos;
    logic       last_word;
    kind_t      in_kind;
    idx_field_t in_idx;

    // The active count saturates at the map size.
    assign active = (cmp_t'(count_reg) > cmp_t'(MAX_CLUSTERS))
                    ? cnt_t'(MAX_CLUSTERS) : cnt_t'(count_reg);

    // Always taken; the user must write configuration only while idle (unenforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg <= cfg_data;
        end
    end

    cba_mark_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_word)
    );

    // Cluster number of the first mark in the word being searched.
    assign base      = cnt_t'(word_addr_reg) << BIT_W;
    assign last_word = (word_addr_reg == addr_t'(NUM_WORDS - 1))
                    || ((cmp_t'(base) + cmp_t'(WORD_W)) >= cmp_t'(active));

    cba_free_find u_find (
        .word   (rd_word),
        .base   (base),
        .active (active),
        .found  (hit),
        .pos    (hit_pos)
    );

    assign in_kind  = kind_t'(s_tuser);
    assign in_idx   = s_tdata[IDX_FIELD_W-1:0];
    assign req_full = cnt_t'(cmp_t'(in_idx));

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        idx_next        = idx_reg;
        word_addr_next  = word_addr_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_free_next   = res_free_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_free_next     = m_free_reg;
        mem_req         = '0;

        // The output register drains independently of the request side.
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next = in_kind;
                    idx_next  = in_idx;
                    if (in_kind == KIND_ALLOC)
                    begin
                        word_addr_next  = '0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_next      = S_CHECK;
                    end
                    else if (cmp_t'(in_idx) >= cmp_t'(active))
                    begin
                        // Index beyond the active count: report, map untouched.
                        res_status_next = ST_RANGE;
                        res_index_next  = in_idx;
                        res_free_next   = 1'b0;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        word_addr_next  = addr_t'(req_full >> BIT_W);
                        bit_next        = req_full[BIT_W-1:0];
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = addr_t'(req_full >> BIT_W);
                        state_next      = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                res_status_next = ST_OK;
                res_index_next  = idx_reg;
                res_free_next   = 1'b0;
                mem_req.wr_addr = word_addr_reg;
                state_next      = S_RESP;
                case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if (hit)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_data = rd_word | (word_t'(1) << hit_pos);
                            res_index_next  = idx_field_t'(base | cnt_t'(hit_pos));
                        end
                        else if (last_word)
                        begin
                            res_status_next = ST_FULL;
                            res_index_next  = '0;
                        end
                        else
                        begin
                            word_addr_next  = word_addr_reg + addr_t'(1);
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = word_addr_reg + addr_t'(1);
                            state_next      = S_CHECK;
                        end
                    end
                    KIND_FREE:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = rd_word & ~(word_t'(1) << bit_reg);
                    end
                    KIND_MARK:
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = rd_word | (word_t'(1) << bit_reg);
                    end
                    default:
                    begin
                        res_free_next = !rd_word[bit_reg];
                    end
                endcase
            end

            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_free_next   = res_free_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_ALLOC;
            idx_reg        <= '0;
            word_addr_reg  <= '0;
            bit_reg        <= '0;
            res_status_reg <= ST_OK;
            res_index_reg  <= '0;
            res_free_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_status_reg   <= ST_OK;
            m_index_reg    <= '0;
            m_free_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            word_addr_reg  <= word_addr_next;
            bit_reg        <= bit_next;
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
            res_free_reg   <= res_free_next;
            m_valid_reg    <= m_valid_next;
            m_status_reg   <= m_status_next;
            m_index_reg    <= m_index_next;
            m_free_reg     <= m_free_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {5'b0, m_free_reg, m_index_reg};

    // A full report always carries a zero index and no free flag.
    `CBA_ASSERT_IMP(a_full_payload, m_tvalid && (m_tuser == ST_FULL),
                    (m_tdata[9:0] == 10'd0) && !m_tdata[10])
    // The free flag only comes with a successful request.
    `CBA_ASSERT_IMP(a_free_needs_ok, m_tvalid && m_tdata[10], m_tuser == ST_OK)
    // An accepted request always leaves the idle state.
    `CBA_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, state_reg != S_IDLE)
    // The map is written only while a request is being checked.
    `CBA_ASSERT_IMP(a_write_in_check, mem_req.wr_en, state_reg == S_CHECK)

endmodule
